// ===== hw/rtl/heightmap_normal_generator_core_defines.svh =====
// assertion macros for the heightmap normal generator checker
`ifndef HEIGHTMAP_NORMAL_GENERATOR_CORE_DEFINES_SVH
`define HEIGHTMAP_NORMAL_GENERATOR_CORE_DEFINES_SVH

// same-cycle implication
`define HNG_ASSERT_IMM(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hng check failed");

// next-cycle implication
`define HNG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hng check failed");

`endif

// ===== hw/rtl/hng_pkg.sv =====
// shared types and constants of the heightmap normal generator
`default_nettype none
package hng_pkg;
    localparam int unsigned ONE_Q14 = 16384;
    localparam int unsigned JOB_DEPTH = 4;

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE   = 2'd2;

    localparam logic [11:0] RST_GRID_WIDTH  = 12'd1024;
    localparam logic [15:0] RST_GRID_HEIGHT = 16'd1024;
    localparam logic [15:0] RST_STEP_SIZE   = 16'd1;

    typedef struct packed {
        logic [11:0] grid_width;
        logic [15:0] grid_height;
        logic [15:0] step_size;
    } t_cfg;

    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dz;
        logic [15:0]        row;
        logic [10:0]        col;
        logic               last;
        logic               done;
    } t_job;
endpackage
`default_nettype wire

// ===== hw/rtl/hng_front.sv =====
// front end: line buffer, grid counters and splitting of samples into normal jobs
`default_nettype none
module hng_front import hng_pkg::*; #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire logic signed [15:0] i_height,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output t_job                    o_job,
    output logic                    o_push,
    input  wire logic               i_full
);
    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned XW = (CW + 1 > 12) ? CW + 1 : 12;

    logic signed [15:0] r_mem [MAX_WIDTH];
    logic signed [15:0] r_rd0, r_rd1, r_h, r_pv, r_prev;
    logic [15:0]        r_row, r_jrow;
    logic [CW-1:0]      r_col, r_jcol;
    logic [2:0]         r_mask;

    logic [XW-1:0]      gw_x, w_eff;
    logic [CW-1:0]      last_col, rd_addr1;
    logic [15:0]        last_row;
    logic               at_last_col, at_last_row, accept;
    logic [2:0]         sel, mask_left;
    logic signed [16:0] e_ctr, e_right, e_h, e_pv;

    always_comb begin
        gw_x = XW'(i_cfg.grid_width);
        if (gw_x == '0) begin
            w_eff = XW'(1);
        end else if (gw_x > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = gw_x;
        end
        last_col    = CW'(w_eff - XW'(1));
        last_row    = i_cfg.grid_height - 16'd1;
        at_last_col = (r_col >= last_col);
        at_last_row = (r_row == last_row);
        rd_addr1    = at_last_col ? r_col : r_col + CW'(1);
    end

    assign o_in_ready = (r_mask == 3'b000);
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[r_col] <= i_height;
            r_rd0        <= r_mem[r_col];
            r_rd1        <= r_mem[rd_addr1];
            r_h          <= i_height;
            r_pv         <= r_prev;
            r_jrow       <= r_row;
            r_jcol       <= r_col;
        end
    end

    // pick pending results in order: row above, left neighbour, corner
    always_comb begin
        if (r_mask[0]) begin
            sel = 3'b001;
        end else if (r_mask[1]) begin
            sel = 3'b010;
        end else begin
            sel = 3'b100;
        end
        mask_left = r_mask & ~sel;
        e_ctr     = 17'(r_rd0);
        e_right   = 17'(r_rd1);
        e_h       = 17'(r_h);
        e_pv      = 17'(r_pv);
        o_job     = '0;
        o_job.last = (mask_left == 3'b000);
        if (sel[0]) begin
            o_job.dx  = e_right - e_ctr;
            o_job.dz  = e_ctr - e_h;
            o_job.row = r_jrow - 16'd1;
            o_job.col = 11'(r_jcol);
        end else if (sel[1]) begin
            o_job.dx  = e_h - e_pv;
            o_job.row = r_jrow;
            o_job.col = 11'(r_jcol - CW'(1));
        end else begin
            o_job.row  = r_jrow;
            o_job.col  = 11'(r_jcol);
            o_job.done = 1'b1;
        end
    end

    assign o_push = (r_mask != 3'b000) && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_prev <= '0;
            r_mask <= '0;
        end else if (accept) begin
            r_prev <= i_height;
            r_mask <= {at_last_row && at_last_col,
                       at_last_row && (r_col != '0),
                       r_row != 16'd0};
            if (at_last_col) begin
                r_col <= '0;
                r_row <= at_last_row ? 16'd0 : r_row + 16'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end else if (o_push) begin
            r_mask <= mask_left;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hng_fifo.sv =====
// short job queue between front end and normalising unit
`default_nettype none
module hng_fifo import hng_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_push,
    output logic      o_full,
    output t_job      o_job,
    input  wire logic i_pop,
    output logic      o_empty
);
    localparam int unsigned AW = $clog2(JOB_DEPTH);

    t_job          r_q [JOB_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(JOB_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (AW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (AW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/hng_back.sv =====
// normalising unit: three lanes of bit-serial rounded unit magnitude search
`default_nettype none
module hng_back import hng_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_step,
    input  wire t_job        i_job,
    input  wire logic        i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [15:0]      o_normal_x,
    output logic [15:0]      o_normal_y,
    output logic [15:0]      o_normal_z,
    output logic [15:0]      o_row_index,
    output logic [10:0]      o_col_index,
    output logic             o_last_of_run,
    output logic             o_grid_done
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_T2   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  r_state;
    logic [3:0]  r_bit;
    logic [15:0] r_mag [3];
    logic        r_neg [3];
    logic [31:0] r_m2  [3];
    logic [14:0] r_q   [3];
    logic [31:0] r_t2  [3];
    logic [48:0] r_ph  [3];
    logic [48:0] r_pl  [3];
    logic [33:0] r_len2;
    logic [15:0] r_row;
    logic [10:0] r_col;
    logic        r_last, r_done;
    logic        r_ov;
    logic [15:0] r_nx, r_ny, r_nz, r_orow;
    logic [10:0] r_ocol;
    logic        r_olast, r_odone;

    logic [14:0] cand [3];
    logic [15:0] tval [3];
    logic        fits [3];
    logic [65:0] lhs  [3];
    logic [65:0] rhs  [3];
    logic [15:0] enc  [3];
    logic        out_free;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cand[k] = r_q[k] | (15'd1 << r_bit);
            tval[k] = {cand[k], 1'b0} - 16'd1;
            lhs[k]  = (66'(r_ph[k]) << 17) + 66'(r_pl[k]);
            rhs[k]  = 66'(r_m2[k]) << 30;
            fits[k] = (cand[k] <= 15'(ONE_Q14)) && (lhs[k] <= rhs[k]);
            enc[k]  = r_neg[k] ? 16'(-{1'b0, r_q[k]}) : {1'b0, r_q[k]};
        end
    end

    assign out_free = !r_ov || i_out_ready;
    assign o_pop    = (r_state == S_IDLE) && !i_empty;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    r_mag[0] <= 16'(i_job.dx[16] ? -i_job.dx : i_job.dx);
                    r_neg[0] <= !i_job.dx[16] && (i_job.dx != '0);
                    r_mag[1] <= i_step;
                    r_neg[1] <= 1'b0;
                    r_mag[2] <= 16'(i_job.dz[16] ? -i_job.dz : i_job.dz);
                    r_neg[2] <= !i_job.dz[16] && (i_job.dz != '0);
                    r_row    <= i_job.row;
                    r_col    <= i_job.col;
                    r_last   <= i_job.last;
                    r_done   <= i_job.done;
                end
            end
            S_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_m2[k] <= r_mag[k] * r_mag[k];
                end
            end
            S_LEN: begin
                r_len2 <= 34'(r_m2[0]) + 34'(r_m2[1]) + 34'(r_m2[2]);
                r_bit  <= 4'd14;
                for (int k = 0; k < 3; k++) begin
                    r_q[k] <= '0;
                end
            end
            S_T2: begin
                for (int k = 0; k < 3; k++) begin
                    r_t2[k] <= tval[k] * tval[k];
                end
            end
            S_MUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_ph[k] <= r_t2[k] * r_len2[33:17];
                    r_pl[k] <= r_t2[k] * r_len2[16:0];
                end
            end
            S_CMP: begin
                for (int k = 0; k < 3; k++) begin
                    if (fits[k]) begin
                        r_q[k] <= cand[k];
                    end
                end
                r_bit <= r_bit - 4'd1;
            end
            default: begin
            end
        endcase
        if (r_state == S_DONE && out_free) begin
            if (r_len2 == '0) begin
                r_nx <= '0;
                r_ny <= 16'(ONE_Q14);
                r_nz <= '0;
            end else begin
                r_nx <= enc[0];
                r_ny <= enc[1];
                r_nz <= enc[2];
            end
            r_orow  <= r_row;
            r_ocol  <= r_col;
            r_olast <= r_last;
            r_odone <= r_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE:  r_state <= i_empty ? S_IDLE : S_SQ;
                S_SQ:    r_state <= S_LEN;
                S_LEN:   r_state <= S_T2;
                S_T2:    r_state <= S_MUL;
                S_MUL:   r_state <= S_CMP;
                S_CMP:   r_state <= (r_bit == 4'd0) ? S_DONE : S_T2;
                S_DONE:  r_state <= out_free ? S_IDLE : S_DONE;
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_ov;
    assign o_normal_x    = r_nx;
    assign o_normal_y    = r_ny;
    assign o_normal_z    = r_nz;
    assign o_row_index   = r_orow;
    assign o_col_index   = r_ocol;
    assign o_last_of_run = r_olast;
    assign o_grid_done   = r_odone;
endmodule
`default_nettype wire

// ===== hw/rtl/heightmap_normal_generator_core.sv =====
// top level: config registers, front end, job queue and normalising unit
// a sample's normal words pass from the front end through the job queue to the normalising unit
// each normal: 15 bit steps in the normalising unit (square, multiply, compare; lanes parallel)
// a sample yields 0 to 3 words, all queued before the next is taken; the queue holds 4 jobs
// reset (synchronous, active low) clears counters, queue, output valid and restores config
// the line buffer is not cleared; entries are valid once written by the row above
`default_nettype none
module heightmap_normal_generator_core import hng_pkg::*; #(
    parameter int unsigned MAX_WIDTH = 2048
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic [15:0] i_height,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic [15:0]      o_normal_x,
    output logic [15:0]      o_normal_y,
    output logic [15:0]      o_normal_z,
    output logic [15:0]      o_row_index,
    output logic [10:0]      o_col_index,
    output logic             o_last_of_run,
    output logic             o_grid_done,
    output logic             o_out_valid,
    input  wire logic        i_out_ready
);
    t_cfg r_cfg;
    t_job push_job, pop_job;
    logic push, pop, full, empty;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= RST_GRID_WIDTH;
            r_cfg.grid_height <= RST_GRID_HEIGHT;
            r_cfg.step_size   <= RST_STEP_SIZE;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_GRID_WIDTH:  r_cfg.grid_width  <= pwdata[11:0];
                REG_GRID_HEIGHT: r_cfg.grid_height <= pwdata[15:0];
                REG_STEP_SIZE:   r_cfg.step_size   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = {20'd0, r_cfg.grid_width};
            REG_GRID_HEIGHT: prdata = {16'd0, r_cfg.grid_height};
            REG_STEP_SIZE:   prdata = {16'd0, r_cfg.step_size};
            default:         prdata = '0;
        endcase
    end

    hng_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_height   (i_height),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_job      (push_job),
        .o_push     (push),
        .i_full     (full)
    );

    hng_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (push_job),
        .i_push  (push),
        .o_full  (full),
        .o_job   (pop_job),
        .i_pop   (pop),
        .o_empty (empty)
    );

    hng_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_cfg.step_size),
        .i_job         (pop_job),
        .i_empty       (empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_normal_x    (o_normal_x),
        .o_normal_y    (o_normal_y),
        .o_normal_z    (o_normal_z),
        .o_row_index   (o_row_index),
        .o_col_index   (o_col_index),
        .o_last_of_run (o_last_of_run),
        .o_grid_done   (o_grid_done)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/hng_checker.sv =====
// port-level checks on the heightmap normal generator, bound to the top level
`default_nettype none
`include "heightmap_normal_generator_core_defines.svh"
module hng_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_normal_x,
    input wire logic [15:0] o_normal_y,
    input wire logic [15:0] o_normal_z,
    input wire logic        o_last_of_run,
    input wire logic        o_grid_done
);
    `HNG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_normal_x) && $stable(o_normal_z))
    `HNG_ASSERT_IMM(a_y_range, i_clk, i_rst_n, o_out_valid, !o_normal_y[15] && (o_normal_y <= 16'd16384))
    `HNG_ASSERT_IMM(a_x_range, i_clk, i_rst_n, o_out_valid, (o_normal_x <= 16'd16384) || (o_normal_x >= 16'hC000))
    `HNG_ASSERT_IMM(a_done_last, i_clk, i_rst_n, o_out_valid && o_grid_done, o_last_of_run)
endmodule

bind heightmap_normal_generator_core hng_checker u_hng_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_normal_x    (o_normal_x),
    .o_normal_y    (o_normal_y),
    .o_normal_z    (o_normal_z),
    .o_last_of_run (o_last_of_run),
    .o_grid_done   (o_grid_done)
);
`default_nettype wire

// ===== dv/tb_heightmap_normal_generator_core.sv =====
// testbench for the heightmap normal generator core: predictor, directed table, random grids
`default_nettype none
module tb_heightmap_normal_generator_core;
    import hng_pkg::*;

    localparam int unsigned MAXW = 2048;
    localparam int unsigned IDLE_LIMIT = 20000;

    typedef struct {
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [15:0] row;
        logic [10:0] col;
        logic        last;
        logic        done;
    } t_normal;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [15:0] i_height;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] o_normal_x;
    logic [15:0] o_normal_y;
    logic [15:0] o_normal_z;
    logic [15:0] o_row_index;
    logic [10:0] o_col_index;
    logic        o_last_of_run;
    logic        o_grid_done;
    logic        o_out_valid;
    logic        i_out_ready;

    heightmap_normal_generator_core uut (.*);

    // predictor state
    logic [11:0]        cfg_width;
    logic [15:0]        cfg_height;
    logic [15:0]        cfg_step;
    logic signed [15:0] line_buf [MAXW];
    logic signed [15:0] prev_h;
    logic [15:0]        cur_row;
    logic [10:0]        cur_col;

    t_normal     normals_due[$];
    logic [15:0] heights_to_send[$];
    int          errors;
    int          idle_cycles;
    bit          hold_off;
    bit          throttle_out;

    initial begin
        i_clk = 1'b0;
    end
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [14:0] unit_mag(longint unsigned mag, longint unsigned len2);
        longint unsigned rhs;
        longint unsigned t;
        int unsigned     lo;
        int unsigned     hi;
        int unsigned     mid;
        rhs = (mag * mag) << 30;
        lo = 0;
        hi = ONE_Q14;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * longint'(mid) - 1;
            if (len2 <= rhs / (t * t)) lo = mid;
            else hi = mid - 1;
        end
        return lo[14:0];
    endfunction

    function automatic logic [15:0] signed_q14(bit neg, logic [14:0] q);
        logic [15:0] v;
        v = {1'b0, q};
        return neg ? 16'(-v) : v;
    endfunction

    function automatic t_normal make_normal(int dx, int dz, logic [15:0] row,
                                            logic [10:0] col, bit done);
        t_normal         n;
        longint unsigned mx;
        longint unsigned mz;
        longint unsigned ms;
        longint unsigned len2;
        mx = dx < 0 ? -dx : dx;
        mz = dz < 0 ? -dz : dz;
        ms = cfg_step;
        len2 = mx * mx + ms * ms + mz * mz;
        if (len2 == 0) begin
            n.nx = 16'd0;
            n.ny = 16'(ONE_Q14);
            n.nz = 16'd0;
        end else begin
            n.nx = signed_q14(dx > 0, unit_mag(mx, len2));
            n.ny = signed_q14(1'b0, unit_mag(ms, len2));
            n.nz = signed_q14(dz > 0, unit_mag(mz, len2));
        end
        n.row = row;
        n.col = col;
        n.last = 1'b0;
        n.done = done;
        return n;
    endfunction

    // predict the normals one sample releases and advance the grid position
    function automatic void predict_normals(logic [15:0] sample);
        t_normal     batch[$];
        int          h;
        int          ctr;
        int          rgt;
        int unsigned w;
        int unsigned c;
        logic [15:0] last_row;
        bit          end_col;
        bit          end_row;
        h = $signed(sample);
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > MAXW) w = MAXW;
        c = cur_col;
        last_row = cfg_height - 16'd1;
        end_col = c >= w - 1;
        end_row = cur_row == last_row;
        if (cur_row > 0) begin
            ctr = line_buf[c];
            rgt = (!end_col && c + 1 < MAXW) ? int'(line_buf[c + 1]) : ctr;
            batch.push_back(make_normal(rgt - ctr, ctr - h, cur_row - 16'd1, 11'(c), 1'b0));
        end
        if (end_row && c > 0)
            batch.push_back(make_normal(h - int'(prev_h), 0, cur_row, 11'(c - 1), 1'b0));
        if (end_row && end_col)
            batch.push_back(make_normal(0, 0, cur_row, 11'(c), 1'b1));
        if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) normals_due.push_back(batch[k]);
        line_buf[c] = sample;
        prev_h = sample;
        if (end_col) begin
            cur_col = '0;
            cur_row = end_row ? 16'd0 : cur_row + 16'd1;
        end else begin
            cur_col = 11'(c + 1);
        end
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  cfg_width = value[11:0];
            REG_GRID_HEIGHT: cfg_height = value[15:0];
            REG_STEP_SIZE:   cfg_step = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(int unsigned w, int unsigned h, int unsigned s);
        write_reg(REG_GRID_WIDTH, w);
        write_reg(REG_GRID_HEIGHT, h);
        write_reg(REG_STEP_SIZE, s);
    endtask

    // send queued samples in bursts, predicting each as it is accepted
    task automatic send_samples();
        int burst;
        int gap;
        burst = 0;
        while (heights_to_send.size() > 0) begin
            if (burst == 0) burst = $urandom_range(1, 20);
            i_height <= heights_to_send[0];
            i_in_valid <= 1'b1;
            do @(posedge i_clk); while (!o_in_ready);
            predict_normals(heights_to_send.pop_front());
            burst--;
            if (heights_to_send.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (burst == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic drain();
        while (normals_due.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_height();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_grid(int unsigned w, int unsigned h, int unsigned s, int unsigned n);
        set_grid(w, h, s);
        repeat (n) heights_to_send.push_back(rand_height());
        send_samples();
        drain();
    endtask

    // receiver stall pattern and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) i_out_ready <= 1'b0;
        else if (throttle_out) i_out_ready <= ($urandom_range(0, 2) != 0);
        else i_out_ready <= 1'b1;
    end

    // output checker
    always @(posedge i_clk) begin
        t_normal e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (normals_due.size() == 0) begin
                $display("%0t unexpected word row %0d col %0d", $time, o_row_index,
                         o_col_index);
                errors++;
            end else begin
                e = normals_due.pop_front();
                if (o_normal_x !== e.nx || o_normal_y !== e.ny || o_normal_z !== e.nz ||
                    o_row_index !== e.row || o_col_index !== e.col ||
                    o_last_of_run !== e.last || o_grid_done !== e.done) begin
                    $display("%0t mismatch expected %h %h %h r%0d c%0d l%b d%b", $time,
                             e.nx, e.ny, e.nz, e.row, e.col, e.last, e.done);
                    $display("%0t          actual   %h %h %h r%0d c%0d l%b d%b", $time,
                             o_normal_x, o_normal_y, o_normal_z, o_row_index,
                             o_col_index, o_last_of_run, o_grid_done);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_off)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_heightmap_normal_generator_core NOT OK");
            $finish;
        end
    end

    // directed table: first grid 3x2, step 1
    logic [15:0] directed_heights [12] = '{16'h0000, 16'h7FFF, 16'h8000,
                                            16'h8000, 16'h7FFF, 16'h0000,
                                            16'h0005, 16'h0005, 16'h0005,
                                            16'h0005, 16'h0005, 16'h0005};

    initial begin
        errors = 0;
        idle_cycles = 0;
        hold_off = 1'b0;
        throttle_out = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_height = '0;
        i_in_valid = 1'b0;
        cfg_width = RST_GRID_WIDTH;
        cfg_height = RST_GRID_HEIGHT;
        cfg_step = RST_STEP_SIZE;
        prev_h = '0;
        cur_row = '0;
        cur_col = '0;
        foreach (line_buf[k]) line_buf[k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two 3x2 grids, extremes and flat surface
        set_grid(3, 2, 1);
        foreach (directed_heights[k]) heights_to_send.push_back(directed_heights[k]);
        send_samples();
        drain();
        // flat surface with zero step gives the straight-up normal
        set_grid(2, 2, 0);
        repeat (4) heights_to_send.push_back(16'h1234);
        send_samples();
        drain();
        if (normals_due.size() == 0 && errors == 0) begin
            set_grid(2, 1, 65535);
            heights_to_send.push_back(16'h7FFF);
            heights_to_send.push_back(16'h8000);
            send_samples();
            drain();
        end
        // width zero acts as one, height one
        set_grid(0, 1, 1);
        heights_to_send.push_back(16'h0001);
        heights_to_send.push_back(16'hFFFF);
        send_samples();
        drain();

        throttle_out = 1'b1;
        run_grid(5, 4, 3, 40);
        run_grid(2, 2, 1, 8);
        run_grid(7, 3, 100, 21);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_off = 1'b0;
            end
            run_grid(4, 5, 65535, 20);
        join
        run_grid(16, 3, 1, 48);
        throttle_out = 1'b0;
        run_grid(3, 6, 7, 36);
        throttle_out = 1'b1;
        run_grid(MAXW, 2, 1, 0);
        run_grid(4095, 2, 2, 10);
        run_grid(1024, 0, 1, 0);
        // height zero: no row reaches the last, so only row-above normals come out
        run_grid(2, 0, 9, 50);

        if (errors == 0 && normals_due.size() == 0)
            $display("tb_heightmap_normal_generator_core OK");
        else
            $display("tb_heightmap_normal_generator_core NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
